// ===== design/bdsl_pkg.sv =====
package bdsl_pkg;

    // Width of the mask fields on the ports
    localparam int FIELD_W        = 4;
    localparam int TIME_W         = 32;
    localparam int REG_W          = 16;
    localparam int CFG_INDEX_W    = 8;
    localparam int NUM_BUTTONS_DEF = 4;

    localparam logic [REG_W-1:0] DEBOUNCE_TIME_RST   = 16'd20;
    localparam logic [REG_W-1:0] LONG_PRESS_TIME_RST = 16'd1000;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TIME   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_TIME = 8'd1;

    typedef struct packed {
        logic [REG_W-1:0] debounce_time;
        logic [REG_W-1:0] long_press_time;
    } bdsl_cfg_t;

    typedef struct packed {
        logic short_ev;
        logic long_ev;
        logic held;
    } bdsl_evt_t;

endpackage

// ===== design/bdsl_cfg.sv =====
module bdsl_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bdsl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bdsl_pkg::REG_W-1:0]       cfg_data,
    output bdsl_pkg::bdsl_cfg_t              cfg
);
    import bdsl_pkg::*;

    logic [REG_W-1:0] debounce_time_reg;
    logic [REG_W-1:0] long_press_time_reg;

    assign cfg_ready = 1'b1;

    // Writes to indexes beyond the register list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_time_reg   <= DEBOUNCE_TIME_RST;
            long_press_time_reg <= LONG_PRESS_TIME_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DEBOUNCE_TIME:   debounce_time_reg   <= cfg_data;
                REG_LONG_PRESS_TIME: long_press_time_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign cfg.debounce_time   = debounce_time_reg;
    assign cfg.long_press_time = long_press_time_reg;

endmodule

// ===== design/bdsl_button.sv =====
module bdsl_button (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [bdsl_pkg::TIME_W-1:0] time_now,
    input  logic                        raw,
    input  bdsl_pkg::bdsl_cfg_t         cfg,
    output bdsl_pkg::bdsl_evt_t         evt
);
    import bdsl_pkg::*;

    logic              prev_raw_reg,    prev_raw_next;
    logic [TIME_W-1:0] change_time_reg, change_time_next;
    logic              held_reg,        held_next;
    logic [TIME_W-1:0] press_start_reg, press_start_next;
    logic              long_done_reg,   long_done_next;

    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] since_press;
    logic              settled;
    logic              long_reached;
    logic              down;

    assign since_change = time_now - change_time_reg;
    assign since_press  = time_now - press_start_reg;
    assign settled      = since_change >= {{(TIME_W-REG_W){1'b0}}, cfg.debounce_time};
    assign long_reached = since_press >= {{(TIME_W-REG_W){1'b0}}, cfg.long_press_time};
    assign down         = !raw;

    always_comb
    begin
        prev_raw_next    = prev_raw_reg;
        change_time_next = change_time_reg;
        held_next        = held_reg;
        press_start_next = press_start_reg;
        long_done_next   = long_done_reg;
        evt.short_ev     = 1'b0;
        evt.long_ev      = 1'b0;
        if (step)
        begin
            if (raw != prev_raw_reg)
            begin
                // restart the settle timer
                prev_raw_next    = raw;
                change_time_next = time_now;
            end
            else if (settled)
            begin
                if (down && !held_reg)
                begin
                    held_next        = 1'b1;
                    press_start_next = time_now;
                    long_done_next   = 1'b0;
                end
                else if (!down && held_reg)
                begin
                    held_next    = 1'b0;
                    evt.short_ev = !long_done_reg && !long_reached;
                end
                else if (down && held_reg && !long_done_reg && long_reached)
                begin
                    long_done_next = 1'b1;
                    evt.long_ev    = 1'b1;
                end
            end
        end
        evt.held = held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg    <= 1'b1;
            change_time_reg <= '0;
            held_reg        <= 1'b0;
            press_start_reg <= '0;
            long_done_reg   <= 1'b0;
        end
        else
        begin
            prev_raw_reg    <= prev_raw_next;
            change_time_reg <= change_time_next;
            held_reg        <= held_next;
            press_start_reg <= press_start_next;
            long_done_reg   <= long_done_next;
        end
    end

endmodule

// ===== design/button_debounce_short_long_press.sv =====
// Debounce and short/long press detection for active-low buttons.
// One poll (timestamp in ms plus raw levels) is taken per clock while the
// output is not stalled. Each poll passes an input register, then a step in
// which every button's state is updated and the event masks are registered,
// and is then shown on the output. The rate of one poll per clock is set by
// that per-button update step, a wrapped 32-bit subtract and compare against
// the debounce and long-press times. Buttons past the 4-bit level field see
// a held-down level and their event bits are not shown. Write the
// configuration registers only while no poll is in flight.
module button_debounce_short_long_press #(
    parameter int NUM_BUTTONS = bdsl_pkg::NUM_BUTTONS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [bdsl_pkg::TIME_W-1:0]      time_now,
    input  logic [bdsl_pkg::FIELD_W-1:0]     raw_levels,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [bdsl_pkg::FIELD_W-1:0]     short_events,
    output logic [bdsl_pkg::FIELD_W-1:0]     long_events,
    output logic [bdsl_pkg::FIELD_W-1:0]     held_mask,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bdsl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bdsl_pkg::REG_W-1:0]       cfg_data
);
    import bdsl_pkg::*;

    bdsl_cfg_t cfg;

    logic               in_full_reg;
    logic [TIME_W-1:0]  in_time_reg;
    logic [FIELD_W-1:0] in_raw_reg;

    logic               out_valid_reg;
    logic [FIELD_W-1:0] short_reg, short_next;
    logic [FIELD_W-1:0] long_reg,  long_next;
    logic [FIELD_W-1:0] held_reg,  held_next;

    logic advance;
    logic step;

    bdsl_evt_t evt [NUM_BUTTONS];

    bdsl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Output register frees up when empty or being taken
    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_full_reg && advance;
    assign in_ready = !in_full_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_time_reg <= time_now;
            in_raw_reg  <= raw_levels;
        end
    end

    for (genvar i = 0; i < NUM_BUTTONS; i++)
    begin : g_btn
        logic raw_bit;
        if (i < FIELD_W)
        begin : g_in_field
            assign raw_bit = in_raw_reg[i];
        end
        else
        begin : g_past_field
            assign raw_bit = 1'b0;
        end

        bdsl_button u_button (
            .clk      (clk),
            .rst_n    (rst_n),
            .step     (step),
            .time_now (in_time_reg),
            .raw      (raw_bit),
            .cfg      (cfg),
            .evt      (evt[i])
        );
    end

    for (genvar j = 0; j < FIELD_W; j++)
    begin : g_mask
        if (j < NUM_BUTTONS)
        begin : g_used
            assign short_next[j] = evt[j].short_ev;
            assign long_next[j]  = evt[j].long_ev;
            assign held_next[j]  = evt[j].held;
        end
        else
        begin : g_unused
            assign short_next[j] = 1'b0;
            assign long_next[j]  = 1'b0;
            assign held_next[j]  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_full_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            short_reg <= short_next;
            long_reg  <= long_next;
            held_reg  <= held_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign short_events = short_reg;
    assign long_events  = long_reg;
    assign held_mask    = held_reg;

endmodule

// ===== design/bdsl_checker.sv =====
module bdsl_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [bdsl_pkg::FIELD_W-1:0] short_events,
    input logic [bdsl_pkg::FIELD_W-1:0] long_events,
    input logic [bdsl_pkg::FIELD_W-1:0] held_mask
);
    import bdsl_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(short_events)
            && $stable(long_events) && $stable(held_mask))
        else $error("stalled result changed");

    // Input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output");

    a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (short_events & long_events) == '0)
        else $error("short and long press on one button");

    // A short press is a release
    a_short_released: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (short_events & held_mask) == '0)
        else $error("short press reported while held");

    // A long press fires while held
    a_long_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (long_events & ~held_mask) == '0)
        else $error("long press reported while released");

endmodule

bind button_debounce_short_long_press bdsl_checker u_bdsl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .short_events (short_events),
    .long_events  (long_events),
    .held_mask    (held_mask)
);
